>>> rtl/deqs_pkg.sv
`default_nettype none
package deqs_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int ACTION_W = 3;
  localparam int POS_W    = 4;
  localparam int ITEM_W   = 32;
  localparam int READ_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 40;

  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_READ_IDX   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_WRITE_IDX  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ_FRONT = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_READ_BACK  = 3'd5;

  localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd3;

  typedef struct packed {
    logic load;
    logic exec;
  } deqs_cmd_t;

endpackage
`default_nettype wire

>>> rtl/deqs_ctrl.sv
`default_nettype none
module deqs_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire                m_tready,
  output deqs_pkg::deqs_cmd_t cmd
);
  import deqs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign cmd.load = s_tvalid && s_tready;
  assign cmd.exec = (state == ST_EXEC);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
      ST_EXEC: state_next = ST_OUT;
      ST_OUT:  if (m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/deqs_datapath.sv
`default_nettype none
module deqs_datapath #(
  parameter int CAPACITY   = deqs_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = deqs_pkg::DEF_DATA_WIDTH
) (
  input  wire                                clk,
  input  wire                                rst,
  input  deqs_pkg::deqs_cmd_t                cmd,
  input  wire  [deqs_pkg::ACTION_W-1:0]      action,
  input  wire  [deqs_pkg::POS_W-1:0]         position,
  input  wire  [deqs_pkg::ITEM_W-1:0]        item_value,
  output logic [deqs_pkg::READ_W-1:0]        read_value,
  output logic [deqs_pkg::COUNT_W-1:0]       element_count,
  output logic                               is_empty,
  output logic [deqs_pkg::STATUS_W-1:0]      status
);
  import deqs_pkg::*;

  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW = $clog2(CAPACITY + 1);

  // latched item
  logic [ACTION_W-1:0]   act_q;
  logic [POS_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] val_q;

  // queue state
  logic [IDXW-1:0] head;
  logic [IDXW-1:0] head_next;
  logic [CNTW-1:0] count;
  logic [CNTW-1:0] count_next;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] mem_q;

  logic                rd_sel;
  logic [STATUS_W-1:0] status_q;

  // exec-cycle decode
  logic [DATA_WIDTH+ITEM_W-1:0] val_ext;
  logic [CNTW+POS_W-1:0]        pos_ext;
  logic [CNTW+POS_W-1:0]        cnt_ext;
  logic [CNTW-1:0]              cnt_dec;
  logic [IDXW-1:0]              logical;
  logic [IDXW:0]                slot_sum;
  logic [IDXW-1:0]              slot;
  logic [IDXW-1:0]              head_dec;
  logic [IDXW-1:0]              addr;
  logic                         full;
  logic                         empty;
  logic                         in_range;
  logic                         we;
  logic                         re;
  logic [STATUS_W-1:0]          sts;
  logic [DATA_WIDTH+READ_W-1:0] rd_ext;
  logic [CNTW+COUNT_W-1:0]      cnt_out_ext;

  assign val_ext = {{DATA_WIDTH{1'b0}}, item_value};
  assign pos_ext = {{CNTW{1'b0}}, pos_q};
  assign cnt_ext = {{POS_W{1'b0}}, count};
  assign cnt_dec = count - CNTW'(1);
  assign full    = (count == CNTW'(CAPACITY));
  assign empty   = (count == '0);
  assign in_range = (pos_ext < cnt_ext);

  // logical index relative to head, per action
  always_comb begin
    logical = '0;
    unique case (act_q)
      ACT_PUSH_BACK:                logical = count[IDXW-1:0];
      ACT_READ_IDX, ACT_WRITE_IDX:  logical = pos_ext[IDXW-1:0];
      ACT_READ_BACK:                logical = cnt_dec[IDXW-1:0];
      default:                      logical = '0;
    endcase
  end

  // circular wrap, sum stays below twice the capacity for every access that is carried out
  assign slot_sum = {1'b0, head} + {1'b0, logical};
  assign slot = (slot_sum >= (IDXW+1)'(CAPACITY)) ?
                IDXW'(slot_sum - (IDXW+1)'(CAPACITY)) : slot_sum[IDXW-1:0];
  assign head_dec = (head == '0) ? IDXW'(CAPACITY - 1) : head - IDXW'(1);

  always_comb begin
    we         = 1'b0;
    re         = 1'b0;
    sts        = STS_OK;
    addr       = slot;
    head_next  = head;
    count_next = count;
    unique case (act_q)
      ACT_PUSH_FRONT: begin
        addr = head_dec;
        if (full) begin
          sts = STS_FULL;
        end else begin
          we         = 1'b1;
          head_next  = head_dec;
          count_next = count + CNTW'(1);
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          sts = STS_FULL;
        end else begin
          we         = 1'b1;
          count_next = count + CNTW'(1);
        end
      end
      ACT_READ_IDX: begin
        if (in_range) re = 1'b1;
        else sts = STS_RANGE;
      end
      ACT_WRITE_IDX: begin
        if (in_range) we = 1'b1;
        else sts = STS_RANGE;
      end
      ACT_READ_FRONT, ACT_READ_BACK: begin
        if (empty) sts = STS_EMPTY;
        else re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= action;
      pos_q <= position;
      val_q <= val_ext[DATA_WIDTH-1:0];
    end
    if (cmd.exec) begin
      rd_sel   <= re;
      status_q <= sts;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && we) mem[addr] <= val_q;
    if (cmd.exec && re) mem_q <= mem[addr];
  end

  assign rd_ext        = {{READ_W{1'b0}}, mem_q};
  assign cnt_out_ext   = {{COUNT_W{1'b0}}, count};
  assign read_value    = rd_sel ? rd_ext[READ_W-1:0] : '0;
  assign element_count = cnt_out_ext[COUNT_W-1:0];
  assign is_empty      = (count == '0);
  assign status        = status_q;

endmodule
`default_nettype wire

>>> rtl/double_ended_queue_store_core.sv
`default_nettype none
// fixed-capacity double-ended queue kept as a circular buffer (head pointer plus count).
// each input transaction carries an action in s_tuser: push front, push back, read or
// write at a logical index (0 is the front), read front or read back. every input
// transaction gives exactly one output transaction with the element read (zero if none),
// the count and empty flag after the action, and a status: ok, index out of range,
// push dropped because full, or front/back access on an empty queue. there are no pops.
// an item is handled in order: it is accepted, then the pointer calculation and the single
// memory access are done, then the result is presented; the block holds one item at a
// time, so the next item is taken after the result transaction.
// reset clears head and count only; storage needs no clearing since only pushed slots
// are ever read.
module double_ended_queue_store_core #(
  parameter int CAPACITY   = deqs_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = deqs_pkg::DEF_DATA_WIDTH
) (
  input  wire                            clk,
  input  wire                            rst,
  // input stream
  input  wire                            s_tvalid,
  output logic                           s_tready,
  input  wire  [deqs_pkg::S_DATA_W-1:0]  s_tdata,  // position[3:0], item_value[35:4], zero pad
  input  wire  [deqs_pkg::ACTION_W-1:0]  s_tuser,  // action[2:0]
  // result stream
  output logic                           m_tvalid,
  input  wire                            m_tready,
  output logic [deqs_pkg::M_DATA_W-1:0]  m_tdata   // read_value[31:0], element_count[36:32],
                                                   // is_empty[37], status[39:38]
);
  import deqs_pkg::*;

  deqs_cmd_t cmd;

  logic [READ_W-1:0]   read_value;
  logic [COUNT_W-1:0]  element_count;
  logic                is_empty;
  logic [STATUS_W-1:0] status;

  // sequencing: idle -> exec -> hold result until taken
  deqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // pointers, storage and result fields
  deqs_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .action        (s_tuser),
    .position      (s_tdata[POS_W-1:0]),
    .item_value    (s_tdata[POS_W+ITEM_W-1:POS_W]),
    .read_value    (read_value),
    .element_count (element_count),
    .is_empty      (is_empty),
    .status        (status)
  );

  // result fields packed from the low bit up
  assign m_tdata = {status, is_empty, element_count, read_value};

endmodule
`default_nettype wire
